// File: rtl/core/mh4_pkg.sv
// ----------------------------------------------------------------------------
// mh4_pkg
// Shared types and constants of the material histogram: field widths,
// operation codes, the item that moves through the ranking chain, and the
// control words of the store and ranking cells.
// ----------------------------------------------------------------------------
package mh4_pkg;

  localparam int KEY_W    = 16;
  localparam int WEIGHT_W = 16;
  localparam int NORM_W   = 8;
  localparam int SLOT_W   = 2;

  // Insertion index carried through the ranking chain, covers up to 64 entries
  localparam int IDX_W    = 6;

  // Full scale of a normalized weight and twice that, the numerator scale
  localparam int NORM_MAX   = 255;
  localparam int NORM_SCALE = 2 * NORM_MAX;

  localparam logic [WEIGHT_W-1:0] WEIGHT_SAT = {WEIGHT_W{1'b1}};

  // Operation codes of an input word
  localparam logic OP_ADD     = 1'b0;
  localparam logic OP_RESOLVE = 1'b1;

  // One histogram entry as it travels through the ranking chain
  typedef struct packed {
    logic                valid;
    logic [KEY_W-1:0]    key;
    logic [WEIGHT_W-1:0] weight;
    logic [IDX_W-1:0]    idx;
  } item_t;

  // Per-cell control of the store chain
  typedef struct packed {
    logic                add;     // add word presented this cycle
    logic                shift;   // move contents one cell toward the head
    logic                live;    // cell index is below the entry count
    logic                wr_new;  // append the add word into this cell
    logic [KEY_W-1:0]    key;
    logic [WEIGHT_W-1:0] weight;
  } st_ctrl_t;

  // Control of the ranking chain
  typedef struct packed {
    logic insert;  // compare and pass down
    logic shift;   // move held items one cell toward the head
  } rk_ctrl_t;

endpackage

// File: rtl/core/mh4_store_cell.sv
// ----------------------------------------------------------------------------
// mh4_store_cell
// One entry of the histogram store: matches the add key, accumulates the
// weight with saturation, takes an appended entry, and hands its contents to
// the neighbor toward the head while the store drains.
// ----------------------------------------------------------------------------
module mh4_store_cell (
  input  logic                           clk_i,
  input  mh4_pkg::st_ctrl_t              ctrl_i,
  input  logic [mh4_pkg::KEY_W-1:0]      next_key_i,
  input  logic [mh4_pkg::WEIGHT_W-1:0]   next_weight_i,
  output logic [mh4_pkg::KEY_W-1:0]      key_o,
  output logic [mh4_pkg::WEIGHT_W-1:0]   weight_o,
  output logic                           match_o
);

  logic [mh4_pkg::KEY_W-1:0]    key_q, key_d;
  logic [mh4_pkg::WEIGHT_W-1:0] weight_q, weight_d;
  logic [mh4_pkg::WEIGHT_W:0]   acc_sum;
  logic [mh4_pkg::WEIGHT_W-1:0] acc_sat;

  // Compare the stored key against the add word
  assign match_o = ctrl_i.live && (key_q == ctrl_i.key);

  // Accumulate with saturation
  assign acc_sum = {1'b0, weight_q} + {1'b0, ctrl_i.weight};
  assign acc_sat = acc_sum[mh4_pkg::WEIGHT_W] ? mh4_pkg::WEIGHT_SAT
                                              : acc_sum[mh4_pkg::WEIGHT_W-1:0];

  // Select shift, append or merge
  always_comb begin
    key_d    = key_q;
    weight_d = weight_q;
    if (ctrl_i.shift) begin
      key_d    = next_key_i;
      weight_d = next_weight_i;
    end else if (ctrl_i.add && ctrl_i.wr_new) begin
      key_d    = ctrl_i.key;
      weight_d = ctrl_i.weight;
    end else if (ctrl_i.add && match_o) begin
      weight_d = acc_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    weight_q <= weight_d;
  end

  assign key_o    = key_q;
  assign weight_o = weight_q;

endmodule

// File: rtl/core/mh4_rank_cell.sv
// ----------------------------------------------------------------------------
// mh4_rank_cell
// One place of the systolic top-N chain: keeps the heavier of its held item
// and the arriving item and passes the other down. Equal weights go to the
// lower insertion index, so entries stored earlier rank higher.
// ----------------------------------------------------------------------------
module mh4_rank_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mh4_pkg::rk_ctrl_t ctrl_i,
  input  mh4_pkg::item_t    in_i,
  input  mh4_pkg::item_t    next_i,
  output mh4_pkg::item_t    held_o,
  output mh4_pkg::item_t    pass_o
);

  logic                         held_v_q, held_v_d;
  logic                         pass_v_q, pass_v_d;
  logic [mh4_pkg::KEY_W-1:0]    held_key_q, held_key_d, pass_key_q, pass_key_d;
  logic [mh4_pkg::WEIGHT_W-1:0] held_w_q, held_w_d, pass_w_q, pass_w_d;
  logic [mh4_pkg::IDX_W-1:0]    held_idx_q, held_idx_d, pass_idx_q, pass_idx_d;
  logic                         in_wins;

  // Heavier weight wins, the lower insertion index breaks a tie
  assign in_wins = (in_i.weight > held_w_q)
                || ((in_i.weight == held_w_q) && (in_i.idx < held_idx_q));

  // Compare and pass down, or shift toward the head
  always_comb begin
    held_v_d   = held_v_q;
    held_key_d = held_key_q;
    held_w_d   = held_w_q;
    held_idx_d = held_idx_q;
    pass_v_d   = pass_v_q;
    pass_key_d = pass_key_q;
    pass_w_d   = pass_w_q;
    pass_idx_d = pass_idx_q;
    if (ctrl_i.shift) begin
      held_v_d   = next_i.valid;
      held_key_d = next_i.key;
      held_w_d   = next_i.weight;
      held_idx_d = next_i.idx;
      pass_v_d   = 1'b0;
    end else if (ctrl_i.insert) begin
      pass_v_d = 1'b0;
      if (in_i.valid) begin
        if (!held_v_q) begin
          held_v_d   = 1'b1;
          held_key_d = in_i.key;
          held_w_d   = in_i.weight;
          held_idx_d = in_i.idx;
        end else if (in_wins) begin
          held_key_d = in_i.key;
          held_w_d   = in_i.weight;
          held_idx_d = in_i.idx;
          pass_v_d   = 1'b1;
          pass_key_d = held_key_q;
          pass_w_d   = held_w_q;
          pass_idx_d = held_idx_q;
        end else begin
          pass_v_d   = 1'b1;
          pass_key_d = in_i.key;
          pass_w_d   = in_i.weight;
          pass_idx_d = in_i.idx;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_v_q <= 1'b0;
      pass_v_q <= 1'b0;
    end else begin
      held_v_q <= held_v_d;
      pass_v_q <= pass_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_key_q <= held_key_d;
    held_w_q   <= held_w_d;
    held_idx_q <= held_idx_d;
    pass_key_q <= pass_key_d;
    pass_w_q   <= pass_w_d;
    pass_idx_q <= pass_idx_d;
  end

  assign held_o = '{valid: held_v_q, key: held_key_q, weight: held_w_q, idx: held_idx_q};
  assign pass_o = '{valid: pass_v_q, key: pass_key_q, weight: pass_w_q, idx: pass_idx_q};

endmodule

// File: rtl/core/mh4_div.sv
// ----------------------------------------------------------------------------
// mh4_div
// Restoring divider for the weight normalization: one quotient bit per cycle
// until NORM_W bits are done. The quotient must fit in NORM_W bits.
// ----------------------------------------------------------------------------
module mh4_div #(
  parameter int NumW = 29,
  parameter int DenW = 21
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [NumW-1:0]           num_i,
  input  logic [DenW-1:0]           den_i,
  output logic                      done_o,
  output logic [mh4_pkg::NORM_W-1:0] quo_o
);

  localparam int StepW = (mh4_pkg::NORM_W > 1) ? $clog2(mh4_pkg::NORM_W) : 1;
  localparam logic [StepW-1:0] LastStep = StepW'(mh4_pkg::NORM_W - 1);

  logic                       busy_q, done_q;
  logic [StepW-1:0]           step_q;
  logic [NumW-1:0]            rem_q, dsh_q;
  logic [mh4_pkg::NORM_W-1:0] quo_q;
  logic                       fits;

  assign fits = (rem_q >= dsh_q);

  // Track the iteration count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Subtract the aligned divisor when it fits, then move it one bit down
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= NumW'(den_i) << (mh4_pkg::NORM_W - 1);
      quo_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[mh4_pkg::NORM_W-2:0], fits};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/core/material_histogram_top4.sv
// ----------------------------------------------------------------------------
// material_histogram_top4
// Add word: one add word per cycle while the block is idle, no result word.
// Resolve word: the N entries drain through the ranking chain and the weights
// are totalled, then each slot passes through load, the divider steps, divider
// done and the output register, plus any output stall.
// Reset clears the entry count, overflow flag, ranking and output valid bits;
// store contents are not cleared and are only read below the entry count.
// ----------------------------------------------------------------------------
module material_histogram_top4 #(
  parameter int MAX_ENTRIES = 16,
  parameter int OUT_SLOTS   = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           operation_i,
  input  logic [mh4_pkg::KEY_W-1:0]      mat_key_i,
  input  logic [mh4_pkg::WEIGHT_W-1:0]   add_weight_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mh4_pkg::SLOT_W-1:0]     slot_o,
  output logic [mh4_pkg::KEY_W-1:0]      out_material_o,
  output logic [mh4_pkg::NORM_W-1:0]     out_weight_o,
  output logic                           overflow_o,
  output logic                           last_o
);

  localparam int CntW   = $clog2(MAX_ENTRIES + 1);
  localparam int IdxW   = mh4_pkg::IDX_W;
  localparam int SlotW  = (OUT_SLOTS > 1) ? $clog2(OUT_SLOTS) : 1;
  localparam int DrainW = $clog2(OUT_SLOTS + 1);
  localparam int SumW   = mh4_pkg::WEIGHT_W + $clog2(OUT_SLOTS + 1);
  localparam int DenW   = SumW + 1;
  localparam int NumW   = SumW + mh4_pkg::NORM_W + 1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SHIFT = 7'b0000010,
    ST_DRAIN = 7'b0000100,
    ST_SUM   = 7'b0001000,
    ST_LOAD  = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_e;

  state_e                       state_q, state_d;
  logic [CntW-1:0]              count_q;
  logic [CntW-1:0]              idx_q;
  logic                         overflow_q;
  logic [DrainW-1:0]            drain_q;
  logic [SlotW-1:0]             slot_q;
  logic [SumW-1:0]              sum_q;
  logic [SumW-1:0]              sum_c;

  logic                         in_acc, add_en, store_shift, head_live;
  logic                         any_match, full, last_c, out_take;
  logic [MAX_ENTRIES-1:0]       match;
  logic [mh4_pkg::KEY_W-1:0]    st_key [MAX_ENTRIES];
  logic [mh4_pkg::WEIGHT_W-1:0] st_w   [MAX_ENTRIES];
  mh4_pkg::st_ctrl_t            st_ctrl [MAX_ENTRIES];

  mh4_pkg::rk_ctrl_t            rk_ctrl;
  mh4_pkg::item_t               head;
  mh4_pkg::item_t               held [OUT_SLOTS];
  mh4_pkg::item_t               pass [OUT_SLOTS];

  logic [NumW-1:0]              num_c;
  logic [DenW-1:0]              den_c;
  logic                         div_done;
  logic [mh4_pkg::NORM_W-1:0]   quo;

  logic                         out_valid_q;
  logic [mh4_pkg::SLOT_W-1:0]   out_slot_q;
  logic [mh4_pkg::KEY_W-1:0]    out_key_q;
  logic [mh4_pkg::NORM_W-1:0]   out_w_q;
  logic                         out_ovf_q, out_last_q;
  logic [SlotW+1:0]             slot_wide;

  // Handshake and add decode
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign add_en      = in_acc && (operation_i == mh4_pkg::OP_ADD);
  assign head_live   = (count_q != '0);
  assign store_shift = (state_q == ST_SHIFT) && head_live;
  assign any_match   = |match;
  assign full        = (count_q == CntW'(MAX_ENTRIES));
  assign last_c      = (slot_q == SlotW'(OUT_SLOTS - 1));
  assign out_take    = (state_q == ST_EMIT) && !out_stall_i;

  // Store chain
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_store
    logic [mh4_pkg::KEY_W-1:0]    nkey;
    logic [mh4_pkg::WEIGHT_W-1:0] nw;

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign nkey = '0;
      assign nw   = '0;
    end else begin : g_body
      assign nkey = st_key[i+1];
      assign nw   = st_w[i+1];
    end

    assign st_ctrl[i] = '{
      add:    add_en,
      shift:  store_shift,
      live:   (CntW'(i) < count_q),
      wr_new: (CntW'(i) == count_q) && !any_match,
      key:    mat_key_i,
      weight: add_weight_i
    };

    mh4_store_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (st_ctrl[i]),
      .next_key_i    (nkey),
      .next_weight_i (nw),
      .key_o         (st_key[i]),
      .weight_o      (st_w[i]),
      .match_o       (match[i])
    );
  end

  // Ranking chain fed from the store head, tagged with the insertion index
  assign rk_ctrl.insert = (state_q == ST_SHIFT) || (state_q == ST_DRAIN);
  assign rk_ctrl.shift  = out_take;
  assign head = '{valid: store_shift, key: st_key[0], weight: st_w[0], idx: IdxW'(idx_q)};

  for (genvar j = 0; j < OUT_SLOTS; j++) begin : g_rank
    mh4_pkg::item_t rin, rnext;

    if (j == 0) begin : g_first
      assign rin = head;
    end else begin : g_mid
      assign rin = pass[j-1];
    end
    if (j == OUT_SLOTS - 1) begin : g_last
      assign rnext = '0;
    end else begin : g_body
      assign rnext = held[j+1];
    end

    mh4_rank_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (rk_ctrl),
      .in_i   (rin),
      .next_i (rnext),
      .held_o (held[j]),
      .pass_o (pass[j])
    );
  end

  // Total the weights of the ranked entries
  always_comb begin
    sum_c = '0;
    for (int j = 0; j < OUT_SLOTS; j++) begin
      if (held[j].valid) begin
        sum_c = sum_c + SumW'(held[j].weight);
      end
    end
  end

  // Divider operands for the slot at the chain head
  assign num_c = NumW'(held[0].weight) * NumW'(mh4_pkg::NORM_SCALE) + NumW'(sum_q);
  assign den_c = {sum_q, 1'b0};

  mh4_div #(
    .NumW (NumW),
    .DenW (DenW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_LOAD),
    .num_i   (num_c),
    .den_i   (den_c),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Sequence a resolve
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc && (operation_i == mh4_pkg::OP_RESOLVE)) state_d = ST_SHIFT;
      ST_SHIFT: if (!head_live) state_d = ST_DRAIN;
      ST_DRAIN: if (drain_q == DrainW'(OUT_SLOTS - 1)) state_d = ST_SUM;
      ST_SUM:   state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_EMIT;
      ST_EMIT:  if (!out_stall_i) state_d = last_c ? ST_IDLE : ST_LOAD;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Hold the control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      overflow_q  <= 1'b0;
      drain_q     <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (add_en && !any_match) begin
        if (full) begin
          overflow_q <= 1'b1;
        end else begin
          count_q <= count_q + CntW'(1);
        end
      end else if (store_shift) begin
        count_q <= count_q - CntW'(1);
      end
      if (state_q == ST_IDLE) begin
        idx_q <= '0;
      end else if (store_shift) begin
        idx_q <= idx_q + CntW'(1);
      end
      if (state_q == ST_SHIFT) begin
        drain_q <= '0;
      end else if (state_q == ST_DRAIN) begin
        drain_q <= drain_q + DrainW'(1);
      end
      if (state_q == ST_SUM) begin
        slot_q <= '0;
      end else if (out_take && !last_c) begin
        slot_q <= slot_q + SlotW'(1);
      end
      if ((state_q == ST_DIV) && div_done) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign slot_wide = {2'b00, slot_q};

  // Register the total and the output word
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SUM) begin
      sum_q <= sum_c;
    end
    if ((state_q == ST_DIV) && div_done) begin
      out_slot_q <= slot_wide[mh4_pkg::SLOT_W-1:0];
      out_key_q  <= held[0].valid ? held[0].key : '0;
      out_w_q    <= (held[0].valid && (sum_q != '0)) ? quo : '0;
      out_ovf_q  <= overflow_q;
      out_last_q <= last_c;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign slot_o         = out_slot_q;
  assign out_material_o = out_key_q;
  assign out_weight_o   = out_w_q;
  assign overflow_o     = out_ovf_q;
  assign last_o         = out_last_q;

endmodule

// File: rtl/core/mh4_checker.sv
// ----------------------------------------------------------------------------
// mh4_checker
// Port-level checks of the material histogram: output word stability, slot
// order within a resolve, sticky overflow, and no input taken while a result
// word is pending.
// ----------------------------------------------------------------------------
module mh4_checker #(
  parameter int OUT_SLOTS = 4
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [mh4_pkg::SLOT_W-1:0]   slot_o,
  input logic [mh4_pkg::KEY_W-1:0]    out_material_o,
  input logic [mh4_pkg::NORM_W-1:0]   out_weight_o,
  input logic                         overflow_o,
  input logic                         last_o
);

  localparam int SlotW = (OUT_SLOTS > 1) ? $clog2(OUT_SLOTS) : 1;

  logic [SlotW-1:0] exp_slot_q;
  logic [SlotW+1:0] exp_wide;
  logic             ovf_seen_q;
  logic             out_take;

  assign out_take = out_valid_o && !out_stall_i;
  assign exp_wide = {2'b00, exp_slot_q};

  // Track the expected slot and the sticky overflow seen on the port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_slot_q <= '0;
      ovf_seen_q <= 1'b0;
    end else begin
      if (out_take) begin
        exp_slot_q <= last_o ? '0 : exp_slot_q + SlotW'(1);
      end
      if (out_valid_o && overflow_o) begin
        ovf_seen_q <= 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_material_o)
      && $stable(out_weight_o) && $stable(slot_o))
    else $error("result word changed while stalled");

  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (slot_o == exp_wide[mh4_pkg::SLOT_W-1:0])
      && (last_o == (exp_slot_q == SlotW'(OUT_SLOTS - 1))))
    else $error("slot out of order");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ovf_seen_q |-> overflow_o)
    else $error("overflow flag dropped");

  a_no_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(in_valid_i && !in_stall_o))
    else $error("input taken while a result word is pending");

endmodule

bind material_histogram_top4 mh4_checker #(
  .OUT_SLOTS (OUT_SLOTS)
) u_mh4_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .slot_o         (slot_o),
  .out_material_o (out_material_o),
  .out_weight_o   (out_weight_o),
  .overflow_o     (overflow_o),
  .last_o         (last_o)
);
